// ----- rtl/sasr_pkg.sv -----
// ----------------------------------------------------------------------------
// sasr_pkg
// Shared types and constants of the sequenced audio sample ring.
// ----------------------------------------------------------------------------
package sasr_pkg;

    localparam int CAPACITY_DEFAULT    = 4096;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam int SAMPLE_W   = 16;
    localparam int SEQ_W      = 64;
    localparam int CNT_W      = 64;
    localparam int OFFSET_W   = 12;
    localparam int TAG_W      = 4;
    localparam int CHCNT_W    = 5;
    localparam int HWM_W      = 13;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [1:0] {
        REQ_WRITE       = 2'd0,
        REQ_WRITE_IL    = 2'd1,
        REQ_READ_SEQ    = 2'd2,
        REQ_READ_LATEST = 2'd3
    } req_type_e_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_UNAVAIL = 2'd1,
        STAT_IGNORED = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT    = 1'b0,
        CFG_SELECTED_CHANNEL = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } state_t;

    // counter update request for one item
    typedef struct packed {
        logic store;
        logic close;
    } stats_cmd_t;

    // counter values as seen on the result channel
    typedef struct packed {
        logic [CNT_W-1:0] committed;
        logic [CNT_W-1:0] dropped;
        logic [HWM_W-1:0] hwm;
        logic [CNT_W-1:0] batches;
    } stats_t;

endpackage

// ----- rtl/sasr_sample_mem.sv -----
// ----------------------------------------------------------------------------
// sasr_sample_mem
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sasr_sample_mem #(
    parameter int  DEPTH  = sasr_pkg::CAPACITY_DEFAULT,
    parameter int  DATA_W = sasr_pkg::SAMPLE_BITS_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/sasr_stats.sv -----
// ----------------------------------------------------------------------------
// sasr_stats
// Committed, dropped, high-watermark and batch counters with open batch length.
// ----------------------------------------------------------------------------
module sasr_stats #(
    parameter int CAPACITY = sasr_pkg::CAPACITY_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sasr_pkg::stats_cmd_t cmd,
    output sasr_pkg::stats_t    cur,
    output sasr_pkg::stats_t    nxt
);

    localparam int LEN_W = $clog2(CAPACITY + 1);

    logic [sasr_pkg::CNT_W-1:0] committed_reg, committed_next;
    logic [sasr_pkg::CNT_W-1:0] dropped_reg, dropped_next;
    logic [sasr_pkg::CNT_W-1:0] batches_reg, batches_next;
    logic [LEN_W-1:0]           peak_reg, peak_next;
    logic [LEN_W-1:0]           len_reg, len_next;

    logic             len_full;
    logic [LEN_W-1:0] len_step;
    logic [LEN_W-1:0] fill;

    always_comb begin
        len_full       = (len_reg == LEN_W'(CAPACITY));
        committed_next = committed_reg + sasr_pkg::CNT_W'(cmd.store);
        dropped_next   = dropped_reg + sasr_pkg::CNT_W'(cmd.store && len_full);
        len_step       = (cmd.store && !len_full) ? len_reg + LEN_W'(1) : len_reg;
        fill           = (committed_next >= sasr_pkg::CNT_W'(CAPACITY)) ?
                         LEN_W'(CAPACITY) : committed_next[LEN_W-1:0];
        peak_next      = peak_reg;
        batches_next   = batches_reg;
        len_next       = len_step;
        // an end mark on an empty batch changes nothing
        if (cmd.close && (len_step != '0)) begin
            peak_next    = (fill > peak_reg) ? fill : peak_reg;
            batches_next = batches_reg + sasr_pkg::CNT_W'(1);
            len_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            committed_reg <= '0;
            dropped_reg   <= '0;
            batches_reg   <= '0;
            peak_reg      <= '0;
            len_reg       <= '0;
        end else begin
            committed_reg <= committed_next;
            dropped_reg   <= dropped_next;
            batches_reg   <= batches_next;
            peak_reg      <= peak_next;
            len_reg       <= len_next;
        end
    end

    always_comb begin
        cur.committed = committed_reg;
        cur.dropped   = dropped_reg;
        cur.hwm       = sasr_pkg::HWM_W'(peak_reg);
        cur.batches   = batches_reg;
        nxt.committed = committed_next;
        nxt.dropped   = dropped_next;
        nxt.hwm       = sasr_pkg::HWM_W'(peak_next);
        nxt.batches   = batches_next;
    end

endmodule

// ----- rtl/sequenced_audio_sample_ring_unit.sv -----
// ----------------------------------------------------------------------------
// sequenced_audio_sample_ring_unit
// Overwriting audio capture ring with sequence-numbered reads and counters.
// ----------------------------------------------------------------------------
// One item is handled at a time. A write is decoded, counted and stored in the
// execute state, which registers its result; a read does the address check and
// memory read in the execute state and registers its result from the memory
// output in the read state. A result still waiting in the output register holds
// the next write in its execute state and the next read in its read state. The
// next item is taken as soon as the previous result sits in the output register,
// even if that result has not been taken yet. Sample i lives in slot i mod
// CAPACITY, so CAPACITY must be a power of two. The store is never cleared: the
// availability checks keep reads away from unwritten slots.
module sequenced_audio_sample_ring_unit #(
    parameter int CAPACITY    = sasr_pkg::CAPACITY_DEFAULT,
    parameter int SAMPLE_BITS = sasr_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic signed [sasr_pkg::SAMPLE_W-1:0] s_sample_value,
    input  logic [sasr_pkg::TAG_W-1:0]        s_channel_tag,
    input  logic                              s_last_of_batch,
    input  logic [sasr_pkg::SEQ_W-1:0]        s_sequence_req,
    input  logic [sasr_pkg::OFFSET_W-1:0]     s_offset,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [sasr_pkg::SAMPLE_W-1:0] m_read_data,
    output logic [1:0]                        m_status,
    output logic [sasr_pkg::SEQ_W-1:0]        m_read_sequence,
    output logic [sasr_pkg::CNT_W-1:0]        m_committed_count,
    output logic [sasr_pkg::CNT_W-1:0]        m_dropped_count,
    output logic [sasr_pkg::HWM_W-1:0]        m_high_watermark,
    output logic [sasr_pkg::CNT_W-1:0]        m_batch_count,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [sasr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sasr_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    localparam int IDX_W = $clog2(CAPACITY);

    // configuration registers
    logic [sasr_pkg::CHCNT_W-1:0] ch_count_reg;
    logic [sasr_pkg::TAG_W-1:0]   sel_ch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_count_reg <= sasr_pkg::CHCNT_W'(1);
            sel_ch_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (sasr_pkg::cfg_reg_t'(cfg_index))
                sasr_pkg::CFG_CHANNEL_COUNT: begin
                    ch_count_reg <= cfg_wr_data[sasr_pkg::CHCNT_W-1:0];
                end
                sasr_pkg::CFG_SELECTED_CHANNEL: begin
                    sel_ch_reg <= cfg_wr_data[sasr_pkg::TAG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // request register
    sasr_pkg::req_type_e_t            rq_type_reg;
    logic [sasr_pkg::SAMPLE_W-1:0]    rq_sample_reg;
    logic [sasr_pkg::TAG_W-1:0]       rq_tag_reg;
    logic                             rq_last_reg;
    logic [sasr_pkg::SEQ_W-1:0]       rq_seq_reg;
    logic [sasr_pkg::OFFSET_W-1:0]    rq_offset_reg;

    sasr_pkg::state_t state_reg, state_next;

    logic in_xfer;
    logic out_free;
    logic is_read;
    logic commit;
    logic load_out;
    logic mem_rd_en;
    logic mem_we;

    assign in_xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            rq_type_reg   <= sasr_pkg::req_type_e_t'(s_req_type);
            rq_sample_reg <= s_sample_value;
            rq_tag_reg    <= s_channel_tag;
            rq_last_reg   <= s_last_of_batch;
            rq_seq_reg    <= s_sequence_req;
            rq_offset_reg <= s_offset;
        end
    end

    assign is_read = (rq_type_reg == sasr_pkg::REQ_READ_SEQ) ||
                     (rq_type_reg == sasr_pkg::REQ_READ_LATEST);

    // counters
    sasr_pkg::stats_cmd_t wr_cmd;
    sasr_pkg::stats_cmd_t stats_cmd;
    sasr_pkg::stats_t     stats_cur;
    sasr_pkg::stats_t     stats_nxt;

    assign stats_cmd = commit ? wr_cmd : '0;

    sasr_stats #(
        .CAPACITY (CAPACITY)
    ) u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stats_cmd),
        .cur     (stats_cur),
        .nxt     (stats_nxt)
    );

    // write decode
    sasr_pkg::status_t wr_status;

    always_comb begin
        wr_cmd    = '0;
        wr_status = sasr_pkg::STAT_OK;
        unique case (rq_type_reg)
            sasr_pkg::REQ_WRITE: begin
                wr_cmd.store = 1'b1;
                wr_cmd.close = rq_last_reg;
            end
            sasr_pkg::REQ_WRITE_IL: begin
                if ((ch_count_reg == '0) ||
                    ({1'b0, sel_ch_reg} >= ch_count_reg)) begin
                    wr_status = sasr_pkg::STAT_IGNORED;
                end else begin
                    wr_cmd.store = (rq_tag_reg == sel_ch_reg);
                    wr_cmd.close = rq_last_reg;
                    wr_status    = (rq_tag_reg == sel_ch_reg) ?
                                   sasr_pkg::STAT_OK : sasr_pkg::STAT_IGNORED;
                end
            end
            sasr_pkg::REQ_READ_SEQ, sasr_pkg::REQ_READ_LATEST: begin
            end
            default: begin
            end
        endcase
    end

    // read address check
    logic [sasr_pkg::SEQ_W-1:0] avail;
    logic [sasr_pkg::SEQ_W-1:0] oldest;
    logic [sasr_pkg::SEQ_W-1:0] seq_by_off;
    logic                       rd_ok;
    logic [sasr_pkg::SEQ_W-1:0] rd_seq;
    logic                       rd_ok_reg;
    logic [sasr_pkg::SEQ_W-1:0] rd_seq_reg;

    always_comb begin
        avail      = (stats_cur.committed >= sasr_pkg::SEQ_W'(CAPACITY)) ?
                     sasr_pkg::SEQ_W'(CAPACITY) : stats_cur.committed;
        oldest     = stats_cur.committed - avail;
        seq_by_off = stats_cur.committed - sasr_pkg::SEQ_W'(1) -
                     sasr_pkg::SEQ_W'(rq_offset_reg);
        rd_ok      = 1'b0;
        rd_seq     = '0;
        unique case (rq_type_reg)
            sasr_pkg::REQ_READ_SEQ: begin
                rd_ok  = (rq_seq_reg != '1) && (rq_seq_reg >= oldest) &&
                         (rq_seq_reg < stats_cur.committed);
                rd_seq = rq_seq_reg;
            end
            sasr_pkg::REQ_READ_LATEST: begin
                rd_ok  = (sasr_pkg::SEQ_W'(rq_offset_reg) < avail);
                rd_seq = seq_by_off;
            end
            sasr_pkg::REQ_WRITE, sasr_pkg::REQ_WRITE_IL: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            rd_ok_reg  <= rd_ok;
            rd_seq_reg <= rd_ok ? rd_seq : '0;
        end
    end

    // sample store
    logic [SAMPLE_BITS-1:0] mem_rdata;

    sasr_sample_mem #(
        .DEPTH  (CAPACITY),
        .DATA_W (SAMPLE_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (stats_cur.committed[IDX_W-1:0]),
        .wr_data (SAMPLE_BITS'(rq_sample_reg)),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_seq[IDX_W-1:0]),
        .rd_data (mem_rdata)
    );

    // sequencer
    assign out_free = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sasr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sasr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sasr_pkg::ST_EXEC;
                end
            end
            sasr_pkg::ST_EXEC: begin
                if (is_read) begin
                    state_next = sasr_pkg::ST_READ;
                end else if (out_free) begin
                    state_next = sasr_pkg::ST_IDLE;
                end
            end
            sasr_pkg::ST_READ: begin
                if (out_free) begin
                    state_next = sasr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sasr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        commit    = 1'b0;
        load_out  = 1'b0;
        mem_rd_en = 1'b0;
        unique case (state_reg)
            sasr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            sasr_pkg::ST_EXEC: begin
                mem_rd_en = is_read;
                commit    = !is_read && out_free;
                load_out  = !is_read && out_free;
            end
            sasr_pkg::ST_READ: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    assign mem_we = commit && wr_cmd.store;

    // output register
    logic                          m_valid_reg;
    logic [sasr_pkg::SAMPLE_W-1:0] out_data_reg;
    sasr_pkg::status_t             out_status_reg;
    logic [sasr_pkg::SEQ_W-1:0]    out_seq_reg;
    sasr_pkg::stats_t              out_stats_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (commit) begin
                out_data_reg   <= '0;
                out_status_reg <= wr_status;
                out_seq_reg    <= '0;
                out_stats_reg  <= stats_nxt;
            end else begin
                out_data_reg   <= rd_ok_reg ? sasr_pkg::SAMPLE_W'(mem_rdata) : '0;
                out_status_reg <= rd_ok_reg ? sasr_pkg::STAT_OK : sasr_pkg::STAT_UNAVAIL;
                out_seq_reg    <= rd_seq_reg;
                out_stats_reg  <= stats_cur;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_read_data       = out_data_reg;
    assign m_status          = out_status_reg;
    assign m_read_sequence   = out_seq_reg;
    assign m_committed_count = out_stats_reg.committed;
    assign m_dropped_count   = out_stats_reg.dropped;
    assign m_high_watermark  = out_stats_reg.hwm;
    assign m_batch_count     = out_stats_reg.batches;

    // checks
    a_committed_only_on_store: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (stats_cur.committed != $past(stats_cur.committed)))
            |-> $past(mem_we))
        else $error("committed count moved without a stored sample");

    a_no_mem_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_rd_en))
        else $error("store written and read in the same cycle");

    a_load_needs_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending result");

    a_unavail_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_status_reg == sasr_pkg::STAT_UNAVAIL))
            |-> ((out_data_reg == '0) && (out_seq_reg == '0)))
        else $error("failed read returned data");

endmodule

// ----- tb/tb_sequenced_audio_sample_ring_unit.sv -----
// ----------------------------------------------------------------------------
// tb_sequenced_audio_sample_ring_unit
// Self-checking bench for the overwriting audio sample ring. A behavioral copy
// of the ring (sample store, sequence window, batch and drop counters) predicts
// every result, which is compared field by field in transfer order. It runs a
// directed pass, one long open batch with reads in between, a long receiver
// hold-off, and random traffic under several channel settings, with random
// idling.
// ----------------------------------------------------------------------------
module tb_sequenced_audio_sample_ring_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = sasr_pkg::CAPACITY_DEFAULT;
    localparam int RING_IDX_W  = $clog2(RING_DEPTH);
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_LIMIT = 5000;
    localparam logic [sasr_pkg::SEQ_W-1:0] SEQ_ALL_ONES = '1;

    typedef struct {
        sasr_pkg::req_type_e_t                kind;
        logic signed [sasr_pkg::SAMPLE_W-1:0] sample;
        logic [sasr_pkg::TAG_W-1:0]           tag;
        logic                                 last;
        logic [sasr_pkg::SEQ_W-1:0]           seq;
        logic [sasr_pkg::OFFSET_W-1:0]        offset;
    } ring_req_t;

    typedef struct {
        logic signed [sasr_pkg::SAMPLE_W-1:0] data;
        sasr_pkg::status_t                    status;
        logic [sasr_pkg::SEQ_W-1:0]           seq;
        logic [sasr_pkg::CNT_W-1:0]           committed;
        logic [sasr_pkg::CNT_W-1:0]           dropped;
        logic [sasr_pkg::HWM_W-1:0]           hwm;
        logic [sasr_pkg::CNT_W-1:0]           batches;
    } ring_result_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                                 s_valid;
    logic                                 s_ready;
    logic [1:0]                           s_req_type;
    logic signed [sasr_pkg::SAMPLE_W-1:0] s_sample_value;
    logic [sasr_pkg::TAG_W-1:0]           s_channel_tag;
    logic                                 s_last_of_batch;
    logic [sasr_pkg::SEQ_W-1:0]           s_sequence_req;
    logic [sasr_pkg::OFFSET_W-1:0]        s_offset;

    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [sasr_pkg::SAMPLE_W-1:0] m_read_data;
    logic [1:0]                           m_status;
    logic [sasr_pkg::SEQ_W-1:0]           m_read_sequence;
    logic [sasr_pkg::CNT_W-1:0]           m_committed_count;
    logic [sasr_pkg::CNT_W-1:0]           m_dropped_count;
    logic [sasr_pkg::HWM_W-1:0]           m_high_watermark;
    logic [sasr_pkg::CNT_W-1:0]           m_batch_count;

    logic                                 cfg_wr_en;
    logic [sasr_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [sasr_pkg::CFG_DATA_W-1:0]      cfg_wr_data;

    // predicted ring state
    logic [sasr_pkg::SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [sasr_pkg::CNT_W-1:0]    written_total;
    logic [sasr_pkg::CNT_W-1:0]    dropped_total;
    logic [sasr_pkg::CNT_W-1:0]    batch_total;
    logic [sasr_pkg::HWM_W-1:0]    fill_peak;
    logic [sasr_pkg::HWM_W-1:0]    batch_len;
    logic [sasr_pkg::CHCNT_W-1:0]  channels_cfg;
    logic [sasr_pkg::TAG_W-1:0]    select_cfg;

    ring_result_t result_q[$];
    ring_result_t want;

    int mismatches     = 0;
    int results_seen   = 0;
    int reads_served   = 0;
    int reads_refused  = 0;
    int writes_ignored = 0;
    int cycle_count    = 0;
    int rx_hold_cycles = 0;
    bit tx_idle_on     = 1'b1;
    bit rx_idle_on     = 1'b1;

    sequenced_audio_sample_ring_unit dut (.*);

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // ring predictor
    // ------------------------------------------------------------------------
    function automatic logic [sasr_pkg::CNT_W-1:0] stored_window();
        return (written_total < RING_DEPTH) ? written_total :
               sasr_pkg::CNT_W'(RING_DEPTH);
    endfunction

    function automatic void ring_store(logic [sasr_pkg::SAMPLE_W-1:0] value);
        ring_mem[written_total[RING_IDX_W-1:0]] = value;
        written_total += 1;
        // a batch longer than the ring starts eating its own samples
        if (batch_len >= RING_DEPTH) dropped_total += 1;
        else batch_len += 1;
    endfunction

    function automatic void ring_close_batch();
        logic [sasr_pkg::CNT_W-1:0] fill;
        if (batch_len == 0) return;
        fill = stored_window();
        if (fill > fill_peak) fill_peak = fill[sasr_pkg::HWM_W-1:0];
        batch_total += 1;
        batch_len = 0;
    endfunction

    function automatic ring_result_t ring_apply(ring_req_t r);
        ring_result_t res;
        logic [sasr_pkg::CNT_W-1:0] avail;
        logic [sasr_pkg::CNT_W-1:0] oldest;
        logic [sasr_pkg::CNT_W-1:0] pos;
        logic hit;
        res.data   = '0;
        res.status = sasr_pkg::STAT_OK;
        res.seq    = '0;
        case (r.kind)
            sasr_pkg::REQ_WRITE: begin
                ring_store(r.sample);
                if (r.last) ring_close_batch();
            end
            sasr_pkg::REQ_WRITE_IL: begin
                if (channels_cfg == 0 || select_cfg >= channels_cfg) begin
                    res.status = sasr_pkg::STAT_IGNORED;
                end else begin
                    if (r.tag == select_cfg) ring_store(r.sample);
                    else res.status = sasr_pkg::STAT_IGNORED;
                    // end mark counts even when the sample itself is skipped
                    if (r.last) ring_close_batch();
                end
            end
            default: begin
                avail  = stored_window();
                oldest = written_total - avail;
                if (r.kind == sasr_pkg::REQ_READ_SEQ) begin
                    pos = r.seq;
                    hit = (pos != SEQ_ALL_ONES) && (pos >= oldest) && (pos < written_total);
                end else begin
                    pos = written_total - 1 - r.offset;
                    hit = r.offset < avail;
                end
                if (hit) begin
                    res.data = ring_mem[pos[RING_IDX_W-1:0]];
                    res.seq  = pos;
                end else begin
                    res.status = sasr_pkg::STAT_UNAVAIL;
                end
            end
        endcase
        res.committed = written_total;
        res.dropped   = dropped_total;
        res.hwm       = fill_peak;
        res.batches   = batch_total;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 2);
        if (roll < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic ring_req_t random_request();
        ring_req_t r;
        int pick;
        logic [sasr_pkg::CNT_W-1:0] avail;
        logic [sasr_pkg::CNT_W-1:0] oldest;
        avail    = stored_window();
        oldest   = written_total - avail;
        r.sample = sasr_pkg::SAMPLE_W'($urandom);
        r.tag    = sasr_pkg::TAG_W'($urandom);
        r.last   = ($urandom_range(0, 99) < 12);
        r.seq    = {$urandom, $urandom};
        r.offset = sasr_pkg::OFFSET_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35) r.kind = sasr_pkg::REQ_WRITE;
        else if (pick < 60) r.kind = sasr_pkg::REQ_WRITE_IL;
        else if (pick < 80) r.kind = sasr_pkg::REQ_READ_SEQ;
        else r.kind = sasr_pkg::REQ_READ_LATEST;
        if ($urandom_range(0, 9) == 0)
            r.sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if (r.kind == sasr_pkg::REQ_WRITE_IL && $urandom_range(0, 99) < 60)
            r.tag = select_cfg;
        pick = $urandom_range(0, 99);
        if (r.kind == sasr_pkg::REQ_READ_SEQ) begin
            if (pick < 70 && avail != 0) begin
                r.seq = oldest + sasr_pkg::SEQ_W'($urandom_range(0, 32'(avail - 1)));
            end else if (pick < 85) begin
                // just around both ends of the live window
                case ($urandom_range(0, 3))
                    0:       r.seq = oldest - 1;
                    1:       r.seq = oldest;
                    2:       r.seq = written_total;
                    default: r.seq = written_total + 1;
                endcase
            end else if (pick >= 95) begin
                r.seq = SEQ_ALL_ONES;
            end
        end
        if (r.kind == sasr_pkg::REQ_READ_LATEST && pick < 80 && avail != 0)
            r.offset = sasr_pkg::OFFSET_W'($urandom_range(0, 32'(avail - 1)));
        return r;
    endfunction

    task automatic send_request(ring_req_t r);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= r.kind;
        s_sample_value  <= r.sample;
        s_channel_tag   <= r.tag;
        s_last_of_batch <= r.last;
        s_sequence_req  <= r.seq;
        s_offset        <= r.offset;
        do @(posedge aclk); while (!s_ready);
        result_q.push_back(ring_apply(r));
    endtask

    task automatic send_op(sasr_pkg::req_type_e_t kind,
                           logic signed [sasr_pkg::SAMPLE_W-1:0] sample,
                           logic [sasr_pkg::TAG_W-1:0] tag, logic last,
                           logic [sasr_pkg::SEQ_W-1:0] seq,
                           logic [sasr_pkg::OFFSET_W-1:0] offset);
        ring_req_t r;
        r.kind   = kind;
        r.sample = sample;
        r.tag    = tag;
        r.last   = last;
        r.seq    = seq;
        r.offset = offset;
        send_request(r);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic settle();
        int n;
        s_valid <= 1'b0;
        for (n = 0; result_q.size() != 0 && n < DRAIN_LIMIT; n++) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(sasr_pkg::cfg_reg_t idx,
                             logic [sasr_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        if (idx == sasr_pkg::CFG_CHANNEL_COUNT) channels_cfg = value;
        else select_cfg = value[sasr_pkg::TAG_W-1:0];
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_channels(int count, int sel);
        settle();
        write_reg(sasr_pkg::CFG_CHANNEL_COUNT, sasr_pkg::CFG_DATA_W'(count));
        write_reg(sasr_pkg::CFG_SELECTED_CHANNEL, sasr_pkg::CFG_DATA_W'(sel));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // empty ring: nothing to read yet
        send_op(sasr_pkg::REQ_READ_LATEST, 16'sh0000, 4'h0, 1'b0, '0, 12'h000);
        send_op(sasr_pkg::REQ_READ_SEQ, 16'sh0000, 4'h0, 1'b0, '0, 12'h000);
        send_op(sasr_pkg::REQ_READ_LATEST, 16'sh0000, 4'h0, 1'b0, '0, 12'hfff);
        send_op(sasr_pkg::REQ_WRITE, 16'sh7fff, 4'h0, 1'b0, '0, 12'h000);
        // open batch is already readable
        send_op(sasr_pkg::REQ_READ_SEQ, 16'sh0000, 4'h0, 1'b0, '0, 12'h000);
        send_op(sasr_pkg::REQ_WRITE, 16'sh8000, 4'hf, 1'b1, SEQ_ALL_ONES, 12'hfff);
        // end mark on an empty batch changes nothing
        send_op(sasr_pkg::REQ_WRITE_IL, 16'sh1234, 4'hf, 1'b1, '0, 12'h000);
        send_op(sasr_pkg::REQ_READ_LATEST, 16'sh0000, 4'h0, 1'b1, '0, 12'h000);
        send_op(sasr_pkg::REQ_READ_LATEST, 16'sh0000, 4'h0, 1'b0, '0, 12'h001);
        send_op(sasr_pkg::REQ_READ_LATEST, 16'sh0000, 4'h0, 1'b0, '0, 12'h002);
        send_op(sasr_pkg::REQ_READ_SEQ, 16'sh0000, 4'h0, 1'b0, 64'd2, 12'h000);
        send_op(sasr_pkg::REQ_READ_SEQ, 16'sh0000, 4'h0, 1'b0, SEQ_ALL_ONES, 12'h000);
        send_op(sasr_pkg::REQ_READ_SEQ, 16'sh0000, 4'h0, 1'b0,
                64'h8000_0000_0000_0001, 12'h000);
        send_op(sasr_pkg::REQ_WRITE_IL, 16'sh0001, 4'h0, 1'b0, '0, 12'h000);
        // other channel: skipped, but still ends the batch
        send_op(sasr_pkg::REQ_WRITE_IL, -16'sh0001, 4'h5, 1'b1, '0, 12'h000);
        send_op(sasr_pkg::REQ_WRITE, 16'sh0000, 4'h0, 1'b1, '0, 12'h000);
        set_channels(0, 0);
        send_op(sasr_pkg::REQ_WRITE_IL, 16'sh4000, 4'h0, 1'b1, '0, 12'h000);
        set_channels(16, 15);
        send_op(sasr_pkg::REQ_WRITE_IL, 16'sh7ffe, 4'hf, 1'b0, '0, 12'h000);
        send_op(sasr_pkg::REQ_WRITE_IL, 16'sh8001, 4'he, 1'b1, '0, 12'h000);
        // selection not below the channel count rejects the frame
        set_channels(4, 4);
        send_op(sasr_pkg::REQ_WRITE_IL, 16'sh2222, 4'h4, 1'b1, '0, 12'h000);
        send_op(sasr_pkg::REQ_READ_SEQ, 16'sh0000, 4'h0, 1'b0, 64'd3, 12'h000);
        send_op(sasr_pkg::REQ_READ_LATEST, 16'sh0000, 4'h0, 1'b0, '0, 12'h000);
    endtask

    // one long open batch, back to back, with reads mixed in
    task automatic test_long_batch();
        ring_req_t r;
        int i;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_channels(2, 1);
        for (i = 0; i < 180; i++) begin
            r = random_request();
            r.last = 1'b0;
            if ($urandom_range(0, 9) != 0) begin
                r.kind = ($urandom_range(0, 3) == 0) ? sasr_pkg::REQ_WRITE_IL :
                                                       sasr_pkg::REQ_WRITE;
                r.tag  = select_cfg;
            end
            send_request(r);
        end
        send_op(sasr_pkg::REQ_READ_LATEST, 16'sh0000, 4'h0, 1'b0, '0, 12'hfff);
        send_op(sasr_pkg::REQ_READ_SEQ, 16'sh0000, 4'h0, 1'b0, written_total - 1, 12'h000);
        send_op(sasr_pkg::REQ_READ_SEQ, 16'sh0000, 4'h0, 1'b0, written_total, 12'h000);
        send_op(sasr_pkg::REQ_WRITE, 16'sh7fff, 4'h0, 1'b1, '0, 12'h000);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        int i;
        tx_idle_on = 1'b0;
        settle();
        rx_hold_cycles = 400;
        for (i = 0; i < 40; i++) send_request(random_request());
        settle();
        for (i = 0; i < 20; i++) send_request(random_request());
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic(int count, int sel, int items);
        int i;
        set_channels(count, sel);
        for (i = 0; i < items; i++) send_request(random_request());
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int n;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
                m_ready <= 1'b0;
                repeat (idle_length()) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: status %0d data %0d seq %0d",
                             m_status, m_read_data, m_read_sequence);
            end else begin
                want = result_q.pop_front();
                case (want.status)
                    sasr_pkg::STAT_OK:      if (want.seq != 0 || want.data != 0 ||
                                                m_read_sequence != 0) reads_served++;
                    sasr_pkg::STAT_UNAVAIL: reads_refused++;
                    default:                writes_ignored++;
                endcase
                if (m_read_data !== want.data || m_status !== want.status ||
                    m_read_sequence !== want.seq || m_committed_count !== want.committed ||
                    m_dropped_count !== want.dropped || m_high_watermark !== want.hwm ||
                    m_batch_count !== want.batches) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d mismatch: expected data %0d status %0d seq %0d",
                                 results_seen, want.data, want.status, want.seq);
                        $display("  committed %0d dropped %0d hwm %0d batches %0d",
                                 want.committed, want.dropped, want.hwm, want.batches);
                        $display("  got data %0d status %0d seq %0d",
                                 m_read_data, m_status, m_read_sequence);
                        $display("  committed %0d dropped %0d hwm %0d batches %0d",
                                 m_committed_count, m_dropped_count, m_high_watermark,
                                 m_batch_count);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_sequenced_audio_sample_ring_unit NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_req_type      = sasr_pkg::REQ_WRITE;
        s_sample_value  = '0;
        s_channel_tag   = '0;
        s_last_of_batch = 1'b0;
        s_sequence_req  = '0;
        s_offset        = '0;
        cfg_wr_en       = 1'b0;
        cfg_index       = sasr_pkg::CFG_CHANNEL_COUNT;
        cfg_wr_data     = '0;
        foreach (ring_mem[i]) ring_mem[i] = '0;
        written_total = '0;
        dropped_total = '0;
        batch_total   = '0;
        fill_peak     = '0;
        batch_len     = '0;
        channels_cfg  = sasr_pkg::CHCNT_W'(1);
        select_cfg    = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_long_batch();
        test_backpressure();
        test_random_traffic(1, 0, 90);
        test_random_traffic(16, 15, 90);
        test_random_traffic(0, 0, 70);
        test_random_traffic(5, 7, 60);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(3, 2, 90);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_random_traffic(16, 0, 90);
        test_random_traffic($urandom_range(1, 16), $urandom_range(0, 15), 90);
        settle();

        if (result_q.size() != 0) begin
            mismatches += result_q.size();
            $display("%0d expected results never arrived", result_q.size());
        end
        $display("%0d results checked: %0d reads served, %0d refused, %0d writes ignored",
                 results_seen, reads_served, reads_refused, writes_ignored);
        $display("ring totals: %0d samples, %0d dropped, %0d batches, high watermark %0d",
                 written_total, dropped_total, batch_total, fill_peak);
        if (mismatches == 0) begin
            $display("tb_sequenced_audio_sample_ring_unit OK");
        end else begin
            $display("tb_sequenced_audio_sample_ring_unit NOT OK");
        end
        $finish;
    end

endmodule
